FILE: hw/rtl/tptgd_pkg.sv
package tptgd_pkg;

	// input and result field widths
	localparam int ROLL_W  = 13;
	localparam int PITCH_W = 12;
	localparam int TS_W    = 32;
	localparam int CFG_W   = 16;
	localparam int EXEC_W  = 16;

	// roll offset from a target, one bit wider than the roll field
	localparam int DR_W = ROLL_W + 1;
	// weighted distance 2*dr^2 + dp^2 stays below 2^26
	localparam int SQ_W = 27;

	// roll targets in 1/16 degree
	localparam logic signed [DR_W-1:0] TGT_ZERO = DR_W'(0);
	localparam logic signed [DR_W-1:0] TGT_MID  = DR_W'(-400);
	localparam logic signed [DR_W-1:0] TGT_LOW  = DR_W'(-800);

	// match limits 2*tol^2 for 25 and 20 degrees
	localparam logic [SQ_W-1:0] LIM_FIRST = SQ_W'(320000);
	localparam logic [SQ_W-1:0] LIM_NEXT  = SQ_W'(204800);

	// configuration registers
	localparam int NUM_REGS  = 6;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_SIXTEENTH = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_EIGHTH    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_QUARTER   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_HALF      = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_HOLD      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_FINISH    = 3'd5;

	localparam logic [CFG_W-1:0] RST_SIXTEENTH = 16'd125;
	localparam logic [CFG_W-1:0] RST_EIGHTH    = 16'd250;
	localparam logic [CFG_W-1:0] RST_QUARTER   = 16'd500;
	localparam logic [CFG_W-1:0] RST_HALF      = 16'd1000;
	localparam logic [CFG_W-1:0] RST_HOLD      = 16'd5000;
	localparam logic [CFG_W-1:0] RST_FINISH    = 16'd1000;

	// result codes
	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_DOWN = 2'd1;
	localparam logic [1:0] ACT_UP   = 2'd2;

	localparam logic [1:0] NOTE_DIV16 = 2'd0;
	localparam logic [1:0] NOTE_DIV8  = 2'd1;
	localparam logic [1:0] NOTE_DIV4  = 2'd2;
	localparam logic [1:0] NOTE_DIV2  = 2'd3;

	localparam int NUM_NOTES = 4;

	typedef enum logic [3:0] {
		PH_IDLE   = 4'b0001,
		PH_FIRST  = 4'b0010,
		PH_SECOND = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	// point matches for one sample
	typedef struct packed {
		logic first_zero;  // roll 0, wide tolerance
		logic first_low;   // roll -50 deg, wide tolerance
		logic next_mid;    // roll -25 deg, narrow tolerance
		logic next_low;    // roll -50 deg, narrow tolerance
		logic next_zero;   // roll 0, narrow tolerance
	} hits_t;

	typedef logic [NUM_NOTES-1:0][CFG_W-1:0] notes_t;

endpackage

FILE: hw/rtl/tptgd_match.sv
module tptgd_match (
	input  logic signed [tptgd_pkg::ROLL_W-1:0]  roll,
	input  logic signed [tptgd_pkg::PITCH_W-1:0] pitch,
	output tptgd_pkg::hits_t                     hits
);
	import tptgd_pkg::*;

	logic signed [DR_W-1:0]     roll_x;
	logic signed [DR_W-1:0]     dr_zero, dr_mid, dr_low;
	logic signed [2*DR_W-1:0]   sq_zero, sq_mid, sq_low;
	logic signed [2*PITCH_W-1:0] sq_pitch;
	logic [SQ_W-1:0]            dist_zero, dist_mid, dist_low;

	assign roll_x  = {roll[ROLL_W-1], roll};
	assign dr_zero = roll_x - TGT_ZERO;
	assign dr_mid  = roll_x - TGT_MID;
	assign dr_low  = roll_x - TGT_LOW;

	assign sq_zero  = dr_zero * dr_zero;
	assign sq_mid   = dr_mid * dr_mid;
	assign sq_low   = dr_low * dr_low;
	assign sq_pitch = pitch * pitch;

	// 2*droll^2 + dpitch^2, pitch target is zero everywhere
	assign dist_zero = (SQ_W'(sq_zero) << 1) + SQ_W'(sq_pitch);
	assign dist_mid  = (SQ_W'(sq_mid) << 1) + SQ_W'(sq_pitch);
	assign dist_low  = (SQ_W'(sq_low) << 1) + SQ_W'(sq_pitch);

	assign hits.first_zero = (dist_zero <= LIM_FIRST);
	assign hits.first_low  = (dist_low <= LIM_FIRST);
	assign hits.next_mid   = (dist_mid <= LIM_NEXT);
	assign hits.next_low   = (dist_low <= LIM_NEXT);
	assign hits.next_zero  = (dist_zero <= LIM_NEXT);

endmodule

FILE: hw/rtl/tptgd_note.sv
module tptgd_note (
	input  logic [tptgd_pkg::CFG_W-1:0] elapsed,
	input  tptgd_pkg::notes_t           notes,
	output logic [1:0]                  note
);
	import tptgd_pkg::*;

	logic [CFG_W-1:0] diff [NUM_NOTES];
	logic [CFG_W-1:0] best_diff;

	function automatic logic [CFG_W-1:0] abs_diff(input logic [CFG_W-1:0] a,
			input logic [CFG_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	always_comb begin
		for (int i = 0; i < NUM_NOTES; i++) begin
			diff[i] = abs_diff(elapsed, notes[i]);
		end
	end

	// strict compare keeps the earliest note on a tie
	always_comb begin
		note      = NOTE_DIV16;
		best_diff = diff[0];
		for (int i = 1; i < NUM_NOTES; i++) begin
			if (diff[i] < best_diff) begin
				best_diff = diff[i];
				note      = 2'(i);
			end
		end
	end

endmodule

FILE: hw/rtl/three_point_tilt_gesture_detector.sv
// channel  | dir | transfer content
// s_axis   | in  | one attitude sample: roll, pitch, timestamp
// m_axis   | out | one result per sample: action in tuser, duration and note in tdata
// apb      | in  | six 16-bit timing registers at byte addresses 0..20
//
// One sample per cycle when not stalled; input register, then result register.
// The phase / template / timestamp loop is combinational from the input register to the state registers.
// arst_n clears the phase, stored times, valid flags and restores register defaults.
// A stalled result holds the result register; the input register keeps accepting
// while it is empty or the result register is free or being drained.
module three_point_tilt_gesture_detector #(
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // roll_angle[12:0], pitch_angle[24:13], timestamp_ms[56:25]

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // execution_ms[15:0], note_index[17:16]
	output logic [1:0]  m_axis_tuser,   // action_code[1:0]

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tptgd_pkg::*;

	// configuration
	logic [CFG_W-1:0]     cfg_q [NUM_REGS];
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 reg_wr;

	// input stage
	logic                      valid_s1;
	logic signed [ROLL_W-1:0]  roll_s1;
	logic signed [PITCH_W-1:0] pitch_s1;
	logic [TS_W-1:0]           ts_s1;

	// result stage
	logic              valid_s2;
	logic [1:0]        action_s2;
	logic [EXEC_W-1:0] exec_s2;
	logic [1:0]        note_s2;

	// gesture state
	phase_t               phase_q, phase_nx;
	logic                 tmpl_q, tmpl_nx;
	logic [TIME_BITS-1:0] start_q, start_nx;
	logic [TIME_BITS-1:0] second_q, second_nx;

	logic                 out_free, advance;
	logic [TIME_BITS-1:0] now, el_first, el_second;
	hits_t                hits;
	notes_t               notes;
	logic [1:0]           note_sel;
	logic [1:0]           action_nx;
	logic [EXEC_W-1:0]    exec_nx;
	logic [1:0]           note_nx;

	// ---------------- APB ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_SIXTEENTH] <= RST_SIXTEENTH;
			cfg_q[REG_EIGHTH]    <= RST_EIGHTH;
			cfg_q[REG_QUARTER]   <= RST_QUARTER;
			cfg_q[REG_HALF]      <= RST_HALF;
			cfg_q[REG_HOLD]      <= RST_HOLD;
			cfg_q[REG_FINISH]    <= RST_FINISH;
		end else if (reg_wr && reg_idx < REG_IDX_W'(NUM_REGS)) begin
			cfg_q[reg_idx] <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx < REG_IDX_W'(NUM_REGS)) begin
			prdata = {{(32 - CFG_W){1'b0}}, cfg_q[reg_idx]};
		end
	end

	// ---------------- handshake ----------------
	assign out_free      = !valid_s2 || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			roll_s1  <= s_axis_tdata[ROLL_W-1:0];
			pitch_s1 <= s_axis_tdata[ROLL_W +: PITCH_W];
			ts_s1    <= s_axis_tdata[ROLL_W + PITCH_W +: TS_W];
		end
	end

	// ---------------- gesture logic ----------------
	tptgd_match u_match (
		.roll  (roll_s1),
		.pitch (pitch_s1),
		.hits  (hits)
	);

	assign notes = {cfg_q[REG_HALF], cfg_q[REG_QUARTER], cfg_q[REG_EIGHTH],
		cfg_q[REG_SIXTEENTH]};

	// only used on completion, where elapsed time is within the 16-bit finish limit
	tptgd_note u_note (
		.elapsed (el_second[CFG_W-1:0]),
		.notes   (notes),
		.note    (note_sel)
	);

	assign now       = TIME_BITS'(ts_s1);
	assign el_first  = now - start_q;
	assign el_second = now - second_q;

	always_comb begin
		phase_nx  = phase_q;
		tmpl_nx   = tmpl_q;
		start_nx  = start_q;
		second_nx = second_q;
		action_nx = ACT_NONE;
		exec_nx   = '0;
		note_nx   = NOTE_DIV16;
		unique case (phase_q)
			PH_IDLE: begin
				if (hits.first_zero) begin
					phase_nx = PH_FIRST;
					tmpl_nx  = 1'b0;
					start_nx = now;
				end else if (hits.first_low) begin
					phase_nx = PH_FIRST;
					tmpl_nx  = 1'b1;
					start_nx = now;
				end
			end
			PH_FIRST: begin
				// both templates share the middle point
				if (el_first > TIME_BITS'(cfg_q[REG_HOLD])) begin
					phase_nx = PH_IDLE;
				end else if (hits.next_mid) begin
					phase_nx  = PH_SECOND;
					second_nx = now;
				end
			end
			PH_SECOND: begin
				if (el_second > TIME_BITS'(cfg_q[REG_FINISH])) begin
					phase_nx = PH_IDLE;
				end else if (tmpl_q ? hits.next_zero : hits.next_low) begin
					phase_nx  = PH_DONE;
					action_nx = tmpl_q ? ACT_UP : ACT_DOWN;
					exec_nx   = el_second[EXEC_W-1:0];
					note_nx   = note_sel;
				end
			end
			PH_DONE: begin
				phase_nx = PH_IDLE;
			end
			default: begin
				phase_nx = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tmpl_q   <= 1'b0;
			start_q  <= '0;
			second_q <= '0;
		end else if (advance) begin
			phase_q  <= phase_nx;
			tmpl_q   <= tmpl_nx;
			start_q  <= start_nx;
			second_q <= second_nx;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_s2 <= action_nx;
			exec_s2   <= exec_nx;
			note_s2   <= note_nx;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = action_s2;
	assign m_axis_tdata  = {6'b0, note_s2, exec_s2};

`ifndef SYNTHESIS
	a_none_is_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && action_s2 == ACT_NONE) |-> (exec_s2 == '0 && note_s2 == NOTE_DIV16))
		else $error("result without action carries nonzero fields");

	a_done_after_action: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && action_nx != ACT_NONE) |=> (phase_q == PH_DONE))
		else $error("completion did not move to done phase");

	a_exec_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && action_nx != ACT_NONE) |-> (exec_nx <= cfg_q[REG_FINISH]))
		else $error("execution time exceeds finish limit");

	a_action_only_from_second: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && action_nx != ACT_NONE) |-> (phase_q == PH_SECOND))
		else $error("action reported outside second-point phase");
`endif

endmodule

FILE: tb/three_point_tilt_gesture_detector_tb.sv
module three_point_tilt_gesture_detector_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tptgd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 200;

	typedef struct packed {
		logic [1:0]        act;
		logic [EXEC_W-1:0] dur;
		logic [1:0]        note;
	} tilt_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;  // roll_angle[12:0], pitch_angle[24:13], timestamp_ms[56:25]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;       // execution_ms[15:0], note_index[17:16]
	logic [1:0]  m_axis_tuser;       // action_code[1:0]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	three_point_tilt_gesture_detector DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state and register mirror
	logic [CFG_W-1:0] timing_reg [NUM_REGS] = '{RST_SIXTEENTH, RST_EIGHTH, RST_QUARTER,
		RST_HALF, RST_HOLD, RST_FINISH};
	phase_t      gest_phase = PH_IDLE;
	logic        tilt_up = 1'b0;
	logic [31:0] first_ms = '0;
	logic [31:0] second_ms = '0;

	logic [63:0] sample_q [$];
	tilt_res_t   tilt_q [$];
	logic        s_took = 1'b0;
	logic        calm = 1'b0;
	logic [31:0] now_ms = '0;
	int          errs = 0;
	int          cyc = 0;

	function automatic bit near_pt(logic signed [ROLL_W-1:0] roll,
			logic signed [PITCH_W-1:0] pitch, logic signed [DR_W-1:0] tgt,
			logic [SQ_W-1:0] lim);
		longint dr, dp;
		dr = longint'(roll) - longint'(tgt);
		dp = longint'(pitch);
		return 2 * dr * dr + dp * dp <= longint'(lim);
	endfunction

	// earliest note wins a tie
	function automatic logic [1:0] closest_note(logic [31:0] el);
		longint best, diff;
		int idx;
		best = 0;
		idx = 0;
		for (int i = 0; i < NUM_NOTES; i++) begin
			diff = (longint'(el) > longint'(timing_reg[i])) ?
				longint'(el) - longint'(timing_reg[i]) : longint'(timing_reg[i]) - longint'(el);
			if (i == 0 || diff < best) begin
				best = diff;
				idx = i;
			end
		end
		return 2'(idx);
	endfunction

	function automatic tilt_res_t tilt_predict(logic [63:0] w);
		logic signed [ROLL_W-1:0]  roll;
		logic signed [PITCH_W-1:0] pitch;
		logic [31:0] now, el;
		tilt_res_t r;
		roll = w[12:0];
		pitch = w[24:13];
		now = w[56:25];
		r = '0;
		r.act = ACT_NONE;
		case (gest_phase)
			PH_IDLE: begin
				if (near_pt(roll, pitch, TGT_ZERO, LIM_FIRST)) begin
					gest_phase = PH_FIRST;
					tilt_up = 1'b0;
					first_ms = now;
				end else if (near_pt(roll, pitch, TGT_LOW, LIM_FIRST)) begin
					gest_phase = PH_FIRST;
					tilt_up = 1'b1;
					first_ms = now;
				end
			end
			PH_FIRST: begin
				el = now - first_ms;
				if (el > 32'(timing_reg[REG_HOLD])) begin
					gest_phase = PH_IDLE;
				end else if (near_pt(roll, pitch, TGT_MID, LIM_NEXT)) begin
					gest_phase = PH_SECOND;
					second_ms = now;
				end
			end
			PH_SECOND: begin
				el = now - second_ms;
				if (el > 32'(timing_reg[REG_FINISH])) begin
					gest_phase = PH_IDLE;
				end else if (near_pt(roll, pitch, tilt_up ? TGT_ZERO : TGT_LOW, LIM_NEXT)) begin
					r.act = tilt_up ? ACT_UP : ACT_DOWN;
					r.dur = el[EXEC_W-1:0];
					r.note = closest_note(el);
					gest_phase = PH_DONE;
				end
			end
			default: gest_phase = PH_IDLE;
		endcase
		return r;
	endfunction

	task automatic cmp_field(string what, int want, int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			errs++;
		end
	endtask

	always @(posedge clk) begin
		tilt_res_t want;
		cyc++;
		s_took <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready)
			tilt_q.push_back(tilt_predict(s_axis_tdata));
		if (m_axis_tvalid && m_axis_tready) begin
			if (tilt_q.size() == 0) begin
				$display("%0t ns: unexpected transfer, expected none, got action %0d dur %0d note %0d",
					$time, m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[17:16]);
				errs++;
			end else begin
				want = tilt_q.pop_front();
				cmp_field("action_code", want.act, m_axis_tuser);
				cmp_field("execution_ms", want.dur, m_axis_tdata[15:0]);
				cmp_field("note_index", want.note, m_axis_tdata[17:16]);
			end
		end
		if (cyc >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// sample driver: new transfer offered once the previous one is taken
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || s_took)) begin
			if (sample_q.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
				s_axis_tdata <= sample_q.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= calm || ($urandom_range(99) >= 19);
	end

	function automatic logic [63:0] pack_sample(int roll, int pitch, logic [31:0] ts);
		return {7'b0, ts, 12'(pitch), 13'(roll)};
	endfunction

	function automatic logic [63:0] near_sample(logic signed [DR_W-1:0] tgt);
		int dr, dp;
		if ($urandom_range(99) < 80) begin
			dr = $urandom_range(440);
			dr -= 220;
			dp = $urandom_range(560);
			dp -= 280;
		end else begin
			dr = $urandom_range(900);
			dr -= 450;
			dp = $urandom_range(1300);
			dp -= 650;
		end
		return pack_sample(int'(tgt) + dr, dp, now_ms);
	endfunction

	function automatic logic [63:0] noise_sample();
		return pack_sample($urandom_range(8191), $urandom_range(4095), now_ms);
	endfunction

	// gap between points: in range, right at the limit, one past it, or wild
	function automatic logic [31:0] step_ms(logic [CFG_W-1:0] lim);
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return $urandom_range(32'(lim), 0);
		else if (r < 72)
			return 32'(lim);
		else if (r < 82)
			return 32'(lim) + 1;
		else if (r < 90)
			return $urandom;
		else
			return '0;
	endfunction

	task automatic push_strays(logic [CFG_W-1:0] lim, inout int cnt);
		int n;
		n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
		repeat (n) begin
			now_ms += $urandom_range(32'(lim) / 4, 0);
			sample_q.push_back(pack_sample(1500 + $urandom_range(1380), $urandom_range(4095),
				now_ms));
			cnt++;
		end
	endtask

	task automatic push_gesture(output int cnt);
		logic up;
		cnt = 0;
		up = 1'($urandom_range(1));
		now_ms += $urandom_range(20000);
		sample_q.push_back(near_sample(up ? TGT_LOW : TGT_ZERO));
		cnt++;
		push_strays(timing_reg[REG_HOLD], cnt);
		now_ms += step_ms(timing_reg[REG_HOLD]);
		sample_q.push_back(near_sample(TGT_MID));
		cnt++;
		push_strays(timing_reg[REG_FINISH], cnt);
		now_ms += step_ms(timing_reg[REG_FINISH]);
		sample_q.push_back(near_sample(up ? TGT_ZERO : TGT_LOW));
		cnt++;
		now_ms += $urandom_range(100);
		sample_q.push_back(noise_sample());
		cnt++;
	endtask

	task automatic reg_write(int idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(4 * idx);
		pwdata <= {16'($urandom), val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx < NUM_REGS)
			timing_reg[idx] = val;
	endtask

	task automatic reg_read(int idx);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= 5'(4 * idx);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(timing_reg[idx])) begin
			$display("%0t ns: register %0d readback, expected %0d, got %0d", $time, idx,
				timing_reg[idx], prdata);
			errs++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// wait until every result is back, then let the pipeline settle
	task automatic drain();
		while (sample_q.size() != 0 || s_axis_tvalid || tilt_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		logic [31:0] t;
		logic [CFG_W-1:0] cfg_set [NUM_REGS];
		int n, k;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int i = 0; i < NUM_REGS; i++)
			reg_read(i);

		// field extremes, no match
		sample_q.push_back(pack_sample(-4096, -2048, 32'd0));
		sample_q.push_back(pack_sample(4095, 2047, 32'hFFFF_FFFF));
		// tilt down, second point right at the hold limit, tie between eighth and quarter
		sample_q.push_back(pack_sample(0, 0, 32'd1000));
		sample_q.push_back(pack_sample(-400, 0, 32'd6000));
		sample_q.push_back(pack_sample(-800, 0, 32'd6375));
		sample_q.push_back(pack_sample(0, 0, 32'd6400));
		// tilt up across timestamp wrap, tie between quarter and half
		t = 32'hFFFF_FF00;
		sample_q.push_back(pack_sample(-800, 0, t));
		sample_q.push_back(pack_sample(-400, 0, t + 100));
		sample_q.push_back(pack_sample(0, 0, t + 850));
		sample_q.push_back(pack_sample(0, 0, t + 900));
		// hold timeout, then a sample on both first-point boundaries picks tilt down
		sample_q.push_back(pack_sample(0, 0, 32'd20000));
		sample_q.push_back(pack_sample(-400, 0, 32'd25001));
		sample_q.push_back(pack_sample(-400, 0, 32'd25002));
		sample_q.push_back(pack_sample(-80, 0, 32'd25010));
		sample_q.push_back(pack_sample(-800, 453, 32'd25020));
		sample_q.push_back(pack_sample(-800, -452, 32'd25030));
		sample_q.push_back(pack_sample(0, 0, 32'd25040));
		// finish timeout
		sample_q.push_back(pack_sample(-800, 0, 32'd30000));
		sample_q.push_back(pack_sample(-400, 0, 32'd30010));
		sample_q.push_back(pack_sample(0, 0, 32'd31011));
		// third point right at the finish limit
		sample_q.push_back(pack_sample(0, 0, 32'd40000));
		sample_q.push_back(pack_sample(-400, 0, 32'd40001));
		sample_q.push_back(pack_sample(-800, 0, 32'd41001));
		sample_q.push_back(pack_sample(0, 0, 32'd41050));
		drain();

		now_ms = $urandom;
		for (int p = 0; p < 6; p++) begin
			case (p)
				1: cfg_set = '{default: '0};
				2: cfg_set = '{default: 16'hFFFF};
				3: cfg_set = '{16'd300, 16'd300, 16'd700, 16'd700, 16'd2000, 16'd1500};
				4: cfg_set = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom_range(65535, 1)), 16'($urandom_range(3000, 1))};
				default: cfg_set = '{RST_SIXTEENTH, RST_EIGHTH, RST_QUARTER, RST_HALF,
					RST_HOLD, RST_FINISH};
			endcase
			if (p > 0) begin
				for (int i = 0; i < NUM_REGS; i++) begin
					reg_write(i, cfg_set[i]);
					reg_read(i);
				end
			end
			if (p == 3) begin
				// unmapped offsets must leave the registers alone
				reg_write(NUM_REGS, 16'($urandom));
				reg_write(NUM_REGS + 1, 16'($urandom));
				for (int i = 0; i < NUM_REGS; i++)
					reg_read(i);
			end
			calm = (p == 3);
			n = 0;
			while (n < PHASE_ITEMS) begin
				if ($urandom_range(99) < 75) begin
					push_gesture(k);
					n += k;
				end else begin
					repeat ($urandom_range(4, 1)) begin
						now_ms += ($urandom_range(9) == 0) ? $urandom : $urandom_range(3000);
						sample_q.push_back(noise_sample());
						n++;
					end
				end
			end
			drain();
		end

		if (errs == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
